[design/bbox_pkg.sv]
// Shared constants and types for the binary image bounding box unit.
package bbox_pkg;

    localparam int WORD_BITS_DEFAULT = 32;

    // Frame dimensions are limited to MAX_DIM pixels on either axis.
    localparam int MAX_DIM = 4096;
    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int CFG_W   = 13;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int RESULT_USED = 1 + 4 * COORD_W + 2 * SIZE_W;
    localparam int RESULT_BITS = ((RESULT_USED + 7) / 8) * 8;

    // Last member lands in the lowest bits.
    typedef struct packed {
        logic [RESULT_BITS-RESULT_USED-1:0] pad;
        logic [SIZE_W-1:0]                  box_height;
        logic [SIZE_W-1:0]                  box_width;
        logic [COORD_W-1:0]                 box_y;
        logic [COORD_W-1:0]                 box_x;
        logic [COORD_W-1:0]                 seek_y;
        logic [COORD_W-1:0]                 seek_x;
        logic                               found;
    } result_t;

endpackage

[design/binary_image_bounding_box_unit.sv]
// Binary image bounding box unit: streams packed pixel words, emits one box per frame.
// Throughput: one pixel word per cycle while the output is not held back, including across frame boundaries.
// Each word is registered on input and processed from that register; the frame
//   result is registered into the output when the last word of the frame is consumed.
// The input stalls only when a finished result waits and another frame end is due.
// Reset (rst_n low, asynchronous): counters cleared, trackers idle, width and height 4096.
module binary_image_bounding_box_unit #(
    parameter int WORD_BITS = bbox_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [WORD_BITS-1:0] pixel_word, zero padding above
    input  logic [((WORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // found, seek_x, seek_y, box_x, box_y, box_width, box_height, zero padding
    output logic [bbox_pkg::RESULT_BITS-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbox_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbox_pkg::CFG_W-1:0]          cfg_data
);

    localparam int CW  = bbox_pkg::COORD_W;
    localparam int SW  = bbox_pkg::SIZE_W;
    localparam int LOW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0] in_word_reg;
    logic                 in_valid_reg;
    logic [SW-1:0]        width_reg;
    logic [SW-1:0]        height_reg;
    logic [CW-1:0]        base_reg;
    logic [CW-1:0]        row_reg;
    logic                 any_reg;
    logic [CW-1:0]        first_x_reg;
    logic [CW-1:0]        first_y_reg;
    logic [CW-1:0]        min_col_reg;
    logic [CW-1:0]        max_col_reg;
    logic [CW-1:0]        min_row_reg;
    logic [CW-1:0]        max_row_reg;
    logic                 out_valid_reg;
    bbox_pkg::result_t    out_reg;

    logic [SW-1:0]        width_eff;
    logic [SW-1:0]        height_eff;
    logic [SW-1:0]        rem;
    logic                 in_row;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] word;
    logic                 hit;
    logic [LOW-1:0]       lo;
    logic [LOW-1:0]       hi;
    logic [CW-1:0]        lo_x;
    logic [CW-1:0]        hi_x;
    logic                 any_next;
    logic [CW-1:0]        first_x_next;
    logic [CW-1:0]        first_y_next;
    logic [CW-1:0]        min_col_next;
    logic [CW-1:0]        max_col_next;
    logic [CW-1:0]        min_row_next;
    logic [CW-1:0]        max_row_next;
    logic [SW:0]          base_sum;
    logic [SW-1:0]        row_inc;
    logic                 row_end;
    logic                 frame_end;
    logic                 advance;
    bbox_pkg::result_t    result;

    always_comb
    begin
        if (width_reg == '0)
            width_eff = SW'(1);
        else if (width_reg > SW'(bbox_pkg::MAX_DIM))
            width_eff = SW'(bbox_pkg::MAX_DIM);
        else
            width_eff = width_reg;
        if (height_reg == '0)
            height_eff = SW'(1);
        else if (height_reg > SW'(bbox_pkg::MAX_DIM))
            height_eff = SW'(bbox_pkg::MAX_DIM);
        else
            height_eff = height_reg;
    end

    // Pixels at or beyond the image width are padding.
    assign in_row = {1'b0, base_reg} < width_eff;
    assign rem    = width_eff - {1'b0, base_reg};

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            mask[b] = in_row && (SW'(b) < rem);
        end
    end

    assign word = in_word_reg & mask;
    assign hit  = |word;

    always_comb
    begin
        lo = '0;
        hi = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (word[b])
                lo = LOW'(b);
        end
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (word[b])
                hi = LOW'(b);
        end
    end

    assign lo_x = base_reg + CW'(lo);
    assign hi_x = base_reg + CW'(hi);

    always_comb
    begin
        any_next     = any_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        if (hit)
        begin
            if (!any_reg)
            begin
                any_next     = 1'b1;
                first_x_next = lo_x;
                first_y_next = row_reg;
            end
            if (lo_x < min_col_reg)
                min_col_next = lo_x;
            if (hi_x > max_col_reg)
                max_col_next = hi_x;
            if (row_reg < min_row_reg)
                min_row_next = row_reg;
            if (row_reg > max_row_reg)
                max_row_next = row_reg;
        end
    end

    // Row ends when the next word would start at or past the width.
    assign base_sum  = {2'b00, base_reg} + (SW+1)'(WORD_BITS);
    assign row_end   = base_sum >= {1'b0, width_eff};
    assign row_inc   = {1'b0, row_reg} + SW'(1);
    assign frame_end = row_end && (row_inc >= height_eff);

    always_comb
    begin
        result = '0;
        if (any_next)
        begin
            result.found      = 1'b1;
            result.seek_x     = first_x_next;
            result.seek_y     = first_y_next;
            result.box_x      = min_col_next;
            result.box_y      = min_row_next;
            result.box_width  = {1'b0, max_col_next} - {1'b0, min_col_next} + SW'(1);
            result.box_height = {1'b0, max_row_next} - {1'b0, min_row_next} + SW'(1);
        end
    end

    assign advance   = in_valid_reg && (!frame_end || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SW'(bbox_pkg::MAX_DIM);
            height_reg <= SW'(bbox_pkg::MAX_DIM);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bbox_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                bbox_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_word_reg <= s_tdata[WORD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            row_reg     <= '0;
            any_reg     <= 1'b0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            min_col_reg <= '1;
            max_col_reg <= '0;
            min_row_reg <= '1;
            max_row_reg <= '0;
        end
        else if (advance)
        begin
            if (frame_end)
            begin
                base_reg    <= '0;
                row_reg     <= '0;
                any_reg     <= 1'b0;
                first_x_reg <= '0;
                first_y_reg <= '0;
                min_col_reg <= '1;
                max_col_reg <= '0;
                min_row_reg <= '1;
                max_row_reg <= '0;
            end
            else
            begin
                if (row_end)
                begin
                    base_reg <= '0;
                    row_reg  <= row_inc[CW-1:0];
                end
                else
                begin
                    base_reg <= base_sum[CW-1:0];
                end
                any_reg     <= any_next;
                first_x_reg <= first_x_next;
                first_y_reg <= first_y_next;
                min_col_reg <= min_col_next;
                max_col_reg <= max_col_next;
                min_row_reg <= min_row_next;
                max_row_reg <= max_row_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && frame_end)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && frame_end)
            out_reg <= result;
    end

`ifndef ASSERT_OFF
    // Empty frame reports all zeros.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |-> (out_reg == '0))
        else $error("empty frame result not all zero");

    // The first set pixel lies in the top row of the box, at or right of its left edge.
    a_seek_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.found) |->
            (out_reg.seek_y == out_reg.box_y && out_reg.box_x <= out_reg.seek_x
             && out_reg.box_width != '0 && out_reg.box_height != '0))
        else $error("seek position outside box");

    // Trackers stay at their reset values until a set pixel is seen.
    a_idle_trackers: assert property (@(posedge clk) disable iff (!rst_n)
        !any_reg |-> (min_col_reg == '1 && min_row_reg == '1
                      && max_col_reg == '0 && max_row_reg == '0))
        else $error("trackers moved without a set pixel");

    // A completed frame always shows up on the output next cycle.
    a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && frame_end) |=> out_valid_reg)
        else $error("frame end did not produce a result word");
`endif

endmodule
